/* sv/nnsb_pkg.sv */
package nnsb_pkg;

	localparam int SRC_STRIDE  = 64;
	localparam int SCREEN_W    = 640;
	localparam int SCREEN_H    = 480;

	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int PIX_W       = 32;
	localparam int OFF_W       = 10;
	localparam int SW_W        = 7;
	localparam int POS_W       = 12;
	localparam int DIM_W       = 10;
	localparam int SCR_W       = 10;
	localparam int Q_W         = SW_W;
	localparam int REM_W       = OFF_W + SW_W;
	localparam int DX_W        = POS_W + 1;
	localparam int CFG_AW      = 5;
	localparam int PDATA_W     = 32;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DEST_LEFT,
		REG_DEST_TOP,
		REG_DEST_WIDTH,
		REG_DEST_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] load_index;
		logic [PIX_W-1:0]  load_pixel;
		logic [OFF_W-1:0]  offset_x;
		logic [OFF_W-1:0]  offset_y;
	} cmd_t;

	typedef struct packed {
		logic             write_enable;
		logic [SCR_W-1:0] screen_x;
		logic [SCR_W-1:0] screen_y;
		logic [PIX_W-1:0] screen_pixel;
	} pix_t;

	typedef struct packed {
		logic load;
		logic draw;
	} stage_ctl_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} div_en_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   q;
	} div_acc_t;

	// restoring division, n quotient bits starting at bit hi, quotient shifts in from the right
	function automatic div_acc_t div_steps(div_acc_t a, logic [DIM_W-1:0] dv, int hi, int n);
		div_acc_t         r;
		logic [REM_W-1:0] sub;
		logic             bit_q;
		r = a;
		for (int i = 0; i < 3; i++) begin
			if (i < n) begin
				sub   = REM_W'(dv) << (hi - i);
				bit_q = (r.rem >= sub);
				if (bit_q) begin
					r.rem = r.rem - sub;
				end
				r.q = {r.q[Q_W-2:0], bit_q};
			end
		end
		return r;
	endfunction

endpackage

/* sv/nearest_neighbor_stretch_blit.sv */
// Six register stages, s1 to s6, carry a command word from the edge that accepts it
// to its pixel word at the output.
// Throughput: one word per cycle, sustained; stages only hold while the word ahead is stalled.
// Rate set by the six-stage pipe: 7-bit quotient in three divider stages, one store port.
// Reset: valid bits clear, source size goes to 56 and the rectangle to zero, asynchronously;
// the source store is not cleared.
module nearest_neighbor_stretch_blit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  nnsb_pkg::cmd_t                 cmd_data,
	output logic                           pix_valid,
	input  logic                           pix_stall,
	output nnsb_pkg::pix_t                 pix_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nnsb_pkg::CFG_AW-1:0]    paddr,
	input  logic [nnsb_pkg::PDATA_W-1:0]   pwdata,
	output logic [nnsb_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import nnsb_pkg::*;

	// ---------------- configuration registers ----------------
	logic [SW_W-1:0]  src_width_q, src_height_q;
	logic [POS_W-1:0] dest_left_q, dest_top_q;
	logic [DIM_W-1:0] dest_width_q, dest_height_q;
	reg_idx_t         cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q   <= SW_W'(56);
			src_height_q  <= SW_W'(56);
			dest_left_q   <= '0;
			dest_top_q    <= '0;
			dest_width_q  <= '0;
			dest_height_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (cfg_idx)
				REG_SRC_WIDTH:   src_width_q   <= pwdata[SW_W-1:0];
				REG_SRC_HEIGHT:  src_height_q  <= pwdata[SW_W-1:0];
				REG_DEST_LEFT:   dest_left_q   <= pwdata[POS_W-1:0];
				REG_DEST_TOP:    dest_top_q    <= pwdata[POS_W-1:0];
				REG_DEST_WIDTH:  dest_width_q  <= pwdata[DIM_W-1:0];
				REG_DEST_HEIGHT: dest_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SRC_WIDTH:   prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT:  prdata = PDATA_W'(src_height_q);
			REG_DEST_LEFT:   prdata = PDATA_W'($signed(dest_left_q));
			REG_DEST_TOP:    prdata = PDATA_W'($signed(dest_top_q));
			REG_DEST_WIDTH:  prdata = PDATA_W'(dest_width_q);
			REG_DEST_HEIGHT: prdata = PDATA_W'(dest_height_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- stage handshake ----------------
	// A stage moves when it is empty or the stage after it moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || !pix_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cmd_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: products, screen position, draw checks ----------------
	logic [REM_W-1:0]     prod_x, prod_y;
	logic signed [DX_W-1:0] dx, dy;
	logic                 size_ok, in_rect, on_screen;
	stage_ctl_t           ctl_in;

	assign prod_x = REM_W'(cmd_data.offset_x) * REM_W'(src_width_q);
	assign prod_y = REM_W'(cmd_data.offset_y) * REM_W'(src_height_q);

	assign dx = $signed({dest_left_q[POS_W-1], dest_left_q})
	          + $signed({{(DX_W-OFF_W){1'b0}}, cmd_data.offset_x});
	assign dy = $signed({dest_top_q[POS_W-1], dest_top_q})
	          + $signed({{(DX_W-OFF_W){1'b0}}, cmd_data.offset_y});

	assign size_ok   = (src_width_q != '0) && (src_height_q != '0)
	                && (dest_width_q != '0) && (dest_height_q != '0);
	assign in_rect   = (cmd_data.offset_x < dest_width_q) && (cmd_data.offset_y < dest_height_q);
	assign on_screen = !dx[DX_W-1] && (dx < $signed(DX_W'(SCREEN_W)))
	                && !dy[DX_W-1] && (dy < $signed(DX_W'(SCREEN_H)));

	assign ctl_in.load = !cmd_data.command;
	assign ctl_in.draw = cmd_data.command && size_ok && in_rect && on_screen;

	stage_ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [ADDR_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [PIX_W-1:0]  lpx_s1, lpx_s2, lpx_s3, lpx_s4;
	logic [SCR_W-1:0]  scx_s1, scx_s2, scx_s3, scx_s4, scx_s5;
	logic [SCR_W-1:0]  scy_s1, scy_s2, scy_s3, scy_s4, scy_s5;
	logic [REM_W-1:0]  prx_s1, pry_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ctl_s1 <= ctl_in;
			idx_s1 <= cmd_data.load_index;
			lpx_s1 <= cmd_data.load_pixel;
			scx_s1 <= dx[SCR_W-1:0];
			scy_s1 <= dy[SCR_W-1:0];
			prx_s1 <= prod_x;
			pry_s1 <= prod_y;
		end
		if (en2) begin
			ctl_s2 <= ctl_s1;
			idx_s2 <= idx_s1;
			lpx_s2 <= lpx_s1;
			scx_s2 <= scx_s1;
			scy_s2 <= scy_s1;
		end
		if (en3) begin
			ctl_s3 <= ctl_s2;
			idx_s3 <= idx_s2;
			lpx_s3 <= lpx_s2;
			scx_s3 <= scx_s2;
			scy_s3 <= scy_s2;
		end
		if (en4) begin
			ctl_s4 <= ctl_s3;
			idx_s4 <= idx_s3;
			lpx_s4 <= lpx_s3;
			scx_s4 <= scx_s3;
			scy_s4 <= scy_s3;
		end
		if (en5) begin
			ctl_s5 <= ctl_s4;
			scx_s5 <= scx_s4;
			scy_s5 <= scy_s4;
		end
	end

	// ---------------- stages 2-4: nearest-neighbour source column/row ----------------
	div_en_t        div_en;
	logic [Q_W-1:0] qx, qy;

	assign div_en = '{s2: en2, s3: en3, s4: en4};

	nnsb_divider u_div_x (
		.clk      (clk),
		.en       (div_en),
		.dividend (prx_s1),
		.divisor  (dest_width_q),
		.quotient (qx)
	);

	nnsb_divider u_div_y (
		.clk      (clk),
		.en       (div_en),
		.dividend (pry_s1),
		.divisor  (dest_height_q),
		.quotient (qy)
	);

	// ---------------- stage 5: source store write / read ----------------
	// Loads and draws hit the store at the same stage, so program order holds.
	logic [PIX_W-1:0] rdata;

	nnsb_store u_store (
		.clk        (clk),
		.en         (en5),
		.valid      (v_s4),
		.ctl        (ctl_s4),
		.load_index (idx_s4),
		.load_pixel (lpx_s4),
		.qx         (qx),
		.qy         (qy),
		.src_width  (src_width_q),
		.src_height (src_height_q),
		.rdata      (rdata)
	);

	// ---------------- stage 6: output register, color-key test ----------------
	pix_t pix_s6;
	logic hit;

	assign hit = ctl_s5.draw && (rdata != '0);

	always_ff @(posedge clk) begin
		if (en6) begin
			pix_s6.write_enable <= hit;
			pix_s6.screen_x     <= hit ? scx_s5 : '0;
			pix_s6.screen_y     <= hit ? scy_s5 : '0;
			pix_s6.screen_pixel <= hit ? rdata  : '0;
		end
	end

	assign pix_valid = v_s6;
	assign pix_data  = pix_s6;

endmodule

/* sv/nnsb_divider.sv */
module nnsb_divider (
	input  logic                            clk,
	input  nnsb_pkg::div_en_t               en,
	input  logic [nnsb_pkg::REM_W-1:0]      dividend,
	input  logic [nnsb_pkg::DIM_W-1:0]      divisor,
	output logic [nnsb_pkg::Q_W-1:0]        quotient
);
	import nnsb_pkg::*;

	localparam int STEP_A = 3;
	localparam int STEP_B = 2;
	localparam int STEP_C = Q_W - STEP_A - STEP_B;

	div_acc_t acc_s2, acc_s3, acc_s4;
	div_acc_t seed;

	assign seed = '{rem: dividend, q: '0};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			acc_s2 <= div_steps(seed, divisor, Q_W - 1, STEP_A);
		end
		if (en.s3) begin
			acc_s3 <= div_steps(acc_s2, divisor, Q_W - 1 - STEP_A, STEP_B);
		end
		if (en.s4) begin
			acc_s4 <= div_steps(acc_s3, divisor, STEP_C - 1, STEP_C);
		end
	end

	assign quotient = acc_s4.q;

endmodule

/* sv/nnsb_store.sv */
module nnsb_store (
	input  logic                            clk,
	input  logic                            en,
	input  logic                            valid,
	input  nnsb_pkg::stage_ctl_t            ctl,
	input  logic [nnsb_pkg::ADDR_W-1:0]     load_index,
	input  logic [nnsb_pkg::PIX_W-1:0]      load_pixel,
	input  logic [nnsb_pkg::Q_W-1:0]        qx,
	input  logic [nnsb_pkg::Q_W-1:0]        qy,
	input  logic [nnsb_pkg::SW_W-1:0]       src_width,
	input  logic [nnsb_pkg::SW_W-1:0]       src_height,
	output logic [nnsb_pkg::PIX_W-1:0]      rdata
);
	import nnsb_pkg::*;

	logic [PIX_W-1:0]  mem [STORE_DEPTH];
	logic [PIX_W-1:0]  rdata_s5;
	logic [Q_W-1:0]    sx, sy;
	logic [ADDR_W-1:0] rd_addr;

	// clamp to last column/row
	assign sx = (qx >= src_width)  ? src_width  - 1'b1 : qx;
	assign sy = (qy >= src_height) ? src_height - 1'b1 : qy;

	// wraps modulo store depth
	assign rd_addr = ADDR_W'(sy) * ADDR_W'(SRC_STRIDE) + ADDR_W'(sx);

	always_ff @(posedge clk) begin
		if (en) begin
			if (valid && ctl.load) begin
				mem[load_index] <= load_pixel;
			end
			rdata_s5 <= mem[rd_addr];
		end
	end

	assign rdata = rdata_s5;

endmodule
